>>> rtl/core/llps_pkg.sv
// ----------------------------------------------------------------------------
// llps_pkg
// Shared constants, types and the arctangent table for the layer line phase
// shift block.
// ----------------------------------------------------------------------------
package llps_pkg;

    localparam int AMP_W    = 24;
    localparam int PHASE_W  = 16;
    localparam int RAD_W    = 24;
    localparam int ORDER_W  = 8;
    localparam int LAYER_W  = 12;
    localparam int OUT_W    = 25;
    localparam int CFG_W    = 24;
    localparam int CFG_A_W  = 3;

    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_ENTRIES = 24;
    localparam int NSTAGE = (CORDIC_STAGES < ANGLE_ENTRIES) ? CORDIC_STAGES : ANGLE_ENTRIES;

    localparam int XW = 35;
    localparam int DW = 33;

    localparam logic [31:0] GAIN_COMP = 32'd2608131496;

    localparam logic [CFG_A_W-1:0] REG_SHIFT_X     = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_TWIST_OMEGA = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_ROTATE_PHI  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_SHIFT_Z     = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_INV_PITCH   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_POLE_ANTI   = 3'd5;

    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

    function automatic logic [31:0] atan_turns(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051D;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2E;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/llps_cordic.sv
// ----------------------------------------------------------------------------
// llps_cordic
// Pipelined rotation-mode CORDIC, one register stage per iteration, with a
// phase tag carried alongside.
// ----------------------------------------------------------------------------
module llps_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  llps_pkg::t_pipe_ctl                  i_ctl,
    input  logic signed [llps_pkg::XW-1:0]       i_x,
    input  logic signed [llps_pkg::DW-1:0]       i_ang,
    input  logic [llps_pkg::PHASE_W-1:0]         i_tag,
    output logic                                 o_vld,
    output logic signed [llps_pkg::XW-1:0]       o_x,
    output logic signed [llps_pkg::XW-1:0]       o_y,
    output logic [llps_pkg::PHASE_W-1:0]         o_tag
);

    localparam int N = llps_pkg::NSTAGE;

    logic signed [llps_pkg::XW-1:0]   c_x   [0:N];
    logic signed [llps_pkg::XW-1:0]   c_y   [0:N];
    logic signed [llps_pkg::DW-1:0]   c_d   [0:N];
    logic [llps_pkg::PHASE_W-1:0]     c_tag [0:N];
    logic                             c_vld [0:N];

    assign c_x[0]   = i_x;
    assign c_y[0]   = '0;
    assign c_d[0]   = i_ang;
    assign c_tag[0] = i_tag;
    assign c_vld[0] = i_ctl.vld;

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic signed [llps_pkg::DW-1:0] ATAN =
            $signed({1'b0, llps_pkg::atan_turns(i)});
        logic signed [llps_pkg::XW-1:0] r_x, r_y, n_x, n_y, xs, ys;
        logic signed [llps_pkg::DW-1:0] r_d, n_d;
        logic [llps_pkg::PHASE_W-1:0]   r_tag;
        logic                           r_vld;

        always_comb begin
            xs = c_x[i] >>> i;
            ys = c_y[i] >>> i;
            if (!c_d[i][llps_pkg::DW-1]) begin
                n_x = c_x[i] - ys;
                n_y = c_y[i] + xs;
                n_d = c_d[i] - ATAN;
            end else begin
                n_x = c_x[i] + ys;
                n_y = c_y[i] - xs;
                n_d = c_d[i] + ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld <= c_vld[i];
            end
            if (i_ctl.en) begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_d   <= n_d;
                r_tag <= c_tag[i];
            end
        end

        assign c_x[i+1]   = r_x;
        assign c_y[i+1]   = r_y;
        assign c_d[i+1]   = r_d;
        assign c_tag[i+1] = r_tag;
        assign c_vld[i+1] = r_vld;
    end

    assign o_vld = c_vld[N];
    assign o_x   = c_x[N];
    assign o_y   = c_y[N];
    assign o_tag = c_tag[N];

endmodule

>>> rtl/core/layer_line_phase_shift.sv
// ----------------------------------------------------------------------------
// layer_line_phase_shift
// Phase shift of one helical layer line coefficient, then polar to
// rectangular conversion of amplitude and shifted phase.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries one coefficient per
//   transfer; output channel o_out_valid / i_out_ready carries the shifted
//   phase and the real and imaginary parts.
//   Registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata; the
//   user must do so only while the block is idle, which the block does not
//   enforce; they take effect for items transferred afterwards.
//   An item passes the product, intra phase and inter phase stages, a register
//   stage for each CORDIC iteration and a rounding and saturation register.
//   Throughput is one item per cycle while the receiver does not stall, set by the fully pipelined CORDIC.
//   Reset clears all valid bits and the registers to zero.
//   When the receiver stalls, the whole pipeline holds; o_in_ready drops
//   only while a result waits at the output and i_out_ready is low.
// ----------------------------------------------------------------------------
module layer_line_phase_shift (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [llps_pkg::CFG_A_W-1:0]           i_cfg_addr,
    input  logic [llps_pkg::CFG_W-1:0]             i_cfg_wdata,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [llps_pkg::AMP_W-1:0]             i_amplitude,
    input  logic [llps_pkg::PHASE_W-1:0]           i_phase_in,
    input  logic [llps_pkg::RAD_W-1:0]             i_radius,
    input  logic signed [llps_pkg::ORDER_W-1:0]    i_bessel_order,
    input  logic signed [llps_pkg::LAYER_W-1:0]    i_layer_number,
    input  logic                                   i_far_side,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [llps_pkg::PHASE_W-1:0]           o_phase_out,
    output logic signed [llps_pkg::OUT_W-1:0]      o_real_part,
    output logic signed [llps_pkg::OUT_W-1:0]      o_imag_part
);

    localparam int PW = llps_pkg::PHASE_W;
    localparam int XW = llps_pkg::XW;
    localparam int DW = llps_pkg::DW;
    localparam int OW = llps_pkg::OUT_W;

    logic signed [23:0] r_shift_x, r_shift_z;
    logic [15:0]        r_twist_omega, r_rotate_phi;
    logic [23:0]        r_inv_pitch;
    logic               r_pole_anti;

    logic w_en;
    llps_pkg::t_pipe_ctl w_ctl;

    logic               r_out_vld;
    logic [PW-1:0]      r_out_phase;
    logic signed [OW-1:0] r_out_re, r_out_im;

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_x     <= '0;
            r_twist_omega <= '0;
            r_rotate_phi  <= '0;
            r_shift_z     <= '0;
            r_inv_pitch   <= '0;
            r_pole_anti   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                llps_pkg::REG_SHIFT_X:     r_shift_x     <= i_cfg_wdata;
                llps_pkg::REG_TWIST_OMEGA: r_twist_omega <= i_cfg_wdata[15:0];
                llps_pkg::REG_ROTATE_PHI:  r_rotate_phi  <= i_cfg_wdata[15:0];
                llps_pkg::REG_SHIFT_Z:     r_shift_z     <= i_cfg_wdata;
                llps_pkg::REG_INV_PITCH:   r_inv_pitch   <= i_cfg_wdata;
                llps_pkg::REG_POLE_ANTI:   r_pole_anti   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // stage 1: products
    logic signed [48:0] c1_rad;
    logic signed [24:0] c1_om, c1_nphi;
    logic signed [36:0] c1_la;
    logic [55:0]        c1_amp;

    assign c1_rad  = $signed({1'b0, i_radius}) * r_shift_x;
    assign c1_om   = $signed({1'b0, r_twist_omega}) * i_bessel_order;
    assign c1_nphi = $signed({1'b0, r_rotate_phi}) * i_bessel_order;
    assign c1_la   = $signed({1'b0, r_inv_pitch}) * i_layer_number;
    assign c1_amp  = {32'd0, i_amplitude} * {24'd0, llps_pkg::GAIN_COMP};

    logic               r1_vld, r1_add;
    logic [PW-1:0]      r1_rad, r1_om, r1_nphi, r1_ph;
    logic signed [36:0] r1_la;
    logic [31:0]        r1_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in_valid;
        end
        if (w_en) begin
            r1_rad  <= c1_rad[31:16];
            r1_om   <= c1_om[15:0];
            r1_nphi <= c1_nphi[15:0];
            r1_la   <= c1_la;
            r1_ph   <= i_phase_in;
            r1_x    <= c1_amp[55:24];
            r1_add  <= (i_far_side == i_bessel_order[llps_pkg::ORDER_W-1]);
        end
    end

    // stage 2: intra phase, axial product
    logic [PW-1:0]      c2_term, c2_p1;
    logic signed [60:0] c2_ax;

    assign c2_term = r1_rad + r1_om;
    assign c2_p1   = r1_add ? (r1_ph + c2_term) : (r1_ph - c2_term);
    assign c2_ax   = r1_la * r_shift_z;

    logic          r2_vld;
    logic [PW-1:0] r2_p1, r2_nphi, r2_ax;
    logic [31:0]   r2_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
        if (w_en) begin
            r2_p1   <= c2_p1;
            r2_nphi <= r1_nphi;
            r2_ax   <= c2_ax[39:24];
            r2_x    <= r1_x;
        end
    end

    // stage 3: inter phase, quadrant fold
    logic [PW-1:0]        c3_pp, c3_p2;
    logic                 c3_fold;
    logic signed [XW-1:0] c3_x0;

    assign c3_pp   = r_pole_anti ? (16'd0 - r2_p1) : r2_p1;
    assign c3_p2   = c3_pp - r2_nphi + r2_ax;
    assign c3_fold = c3_p2[PW-1] ^ c3_p2[PW-2];
    assign c3_x0   = $signed({{(XW-32){1'b0}}, r2_x});

    logic                 r3_vld;
    logic [PW-1:0]        r3_p2;
    logic signed [XW-1:0] r3_x;
    logic signed [DW-1:0] r3_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
        if (w_en) begin
            r3_p2  <= c3_p2;
            r3_x   <= c3_fold ? -c3_x0 : c3_x0;
            r3_ang <= $signed({c3_p2[PW-1] ^ c3_fold, c3_p2[PW-1] ^ c3_fold,
                               c3_p2[PW-2:0], 16'd0});
        end
    end

    assign w_ctl.en  = w_en;
    assign w_ctl.vld = r3_vld;

    logic                 w_c_vld;
    logic signed [XW-1:0] w_c_x, w_c_y;
    logic [PW-1:0]        w_c_tag;

    llps_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     (r3_x),
        .i_ang   (r3_ang),
        .i_tag   (r3_p2),
        .o_vld   (w_c_vld),
        .o_x     (w_c_x),
        .o_y     (w_c_y),
        .o_tag   (w_c_tag)
    );

    // round and saturate
    function automatic logic signed [OW-1:0] rnd_sat(input logic signed [XW-1:0] v);
        logic signed [XW:0]   s;
        logic signed [XW-8:0] r;
        logic signed [XW-8:0] lim_hi, lim_lo;
        s = {v[XW-1], v} + (XW+1)'(128);
        r = s[XW:8];
        lim_hi = (XW-7)'((1 << (OW-1)) - 1);
        lim_lo = -(XW-7)'(1 << (OW-1));
        if (r > lim_hi) begin
            return lim_hi[OW-1:0];
        end else if (r < lim_lo) begin
            return lim_lo[OW-1:0];
        end
        return r[OW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_c_vld;
        end
        if (w_en) begin
            r_out_phase <= w_c_tag;
            r_out_re    <= rnd_sat(w_c_x);
            r_out_im    <= rnd_sat(w_c_y);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_phase_out = r_out_phase;
    assign o_real_part = r_out_re;
    assign o_imag_part = r_out_im;

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready inconsistent with output stall");
    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r1_vld) && $stable(r3_vld) && $stable(r3_p2))
        else $error("pipeline moved during stall");
`endif

endmodule

>>> tb/layer_line_phase_shift_tb.sv
// ----------------------------------------------------------------------------
// layer_line_phase_shift_tb
// Self-checking bench for the layer line phase shift block: drives
// coefficients with random gaps, predicts the shifted phase and the CORDIC
// rectangular parts in a behavioural model, and compares every transfer.
// ----------------------------------------------------------------------------
module layer_line_phase_shift_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 20;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic [llps_pkg::PHASE_W-1:0]     phase;
        logic signed [llps_pkg::OUT_W-1:0] re;
        logic signed [llps_pkg::OUT_W-1:0] im;
    } t_coeff_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [llps_pkg::CFG_A_W-1:0] i_cfg_addr = '0;
    logic [llps_pkg::CFG_W-1:0] i_cfg_wdata = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [llps_pkg::AMP_W-1:0] i_amplitude = '0;
    logic [llps_pkg::PHASE_W-1:0] i_phase_in = '0;
    logic [llps_pkg::RAD_W-1:0] i_radius = '0;
    logic signed [llps_pkg::ORDER_W-1:0] i_bessel_order = '0;
    logic signed [llps_pkg::LAYER_W-1:0] i_layer_number = '0;
    logic i_far_side = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [llps_pkg::PHASE_W-1:0] o_phase_out;
    logic signed [llps_pkg::OUT_W-1:0] o_real_part;
    logic signed [llps_pkg::OUT_W-1:0] o_imag_part;

    logic signed [23:0] m_shift_x = '0;
    logic [15:0] m_omega = '0;
    logic [15:0] m_phi = '0;
    logic signed [23:0] m_shift_z = '0;
    logic [23:0] m_inv_pitch = '0;
    logic m_pole_anti = 1'b0;

    t_coeff_out pending_coeffs[$];
    bit failed = 1'b0;
    int idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    layer_line_phase_shift u_top (.*);

    localparam logic [31:0] ATAN_TBL [24] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

    function automatic logic signed [llps_pkg::OUT_W-1:0] round_clamp(input longint v);
        longint r;
        r = (v + 128) >>> 8;
        if (r > 64'sd16777215) r = 64'sd16777215;
        if (r < -64'sd16777216) r = -64'sd16777216;
        return r[llps_pkg::OUT_W-1:0];
    endfunction

    function automatic t_coeff_out shift_coeff(input logic [23:0] amp,
            input logic [15:0] ph, input logic [23:0] rad,
            input logic signed [7:0] n, input logic signed [11:0] l, input logic far);
        t_coeff_out r;
        longint term, axial, x, y, d, xs, ys;
        logic [15:0] p1, p2;
        logic [31:0] ang;
        term = ((longint'(rad) * longint'(m_shift_x)) >>> 16) + longint'(m_omega) * n;
        if (far == (n < 0)) p1 = ph + term[15:0];
        else p1 = ph - term[15:0];
        axial = (longint'(l) * longint'(m_inv_pitch) * longint'(m_shift_z)) >>> 24;
        p2 = (m_pole_anti ? -p1 : p1) - 16'(longint'(n) * m_phi) + axial[15:0];
        x = (longint'(amp) * longint'(llps_pkg::GAIN_COMP)) >>> 24;
        y = 0;
        ang = {p2, 16'h0};
        if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
            x = -x;
            ang = ang + 32'h80000000;
        end
        d = longint'(signed'(ang));
        for (int i = 0; i < llps_pkg::NSTAGE; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (d >= 0) begin
                x = x - ys; y = y + xs; d = d - ATAN_TBL[i];
            end else begin
                x = x + ys; y = y - xs; d = d + ATAN_TBL[i];
            end
        end
        r.phase = p2;
        r.re = round_clamp(x);
        r.im = round_clamp(y);
        return r;
    endfunction

    task automatic write_reg(input logic [llps_pkg::CFG_A_W-1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        case (idx)
            llps_pkg::REG_SHIFT_X:     m_shift_x = val;
            llps_pkg::REG_TWIST_OMEGA: m_omega = val[15:0];
            llps_pkg::REG_ROTATE_PHI:  m_phi = val[15:0];
            llps_pkg::REG_SHIFT_Z:     m_shift_z = val;
            llps_pkg::REG_INV_PITCH:   m_inv_pitch = val;
            llps_pkg::REG_POLE_ANTI:   m_pole_anti = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_coeffs.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic send_coeff(input logic [23:0] amp, input logic [15:0] ph,
            input logic [23:0] rad, input logic signed [7:0] n,
            input logic signed [11:0] l, input logic far);
        int gap;
        gap = $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_amplitude <= amp; i_phase_in <= ph; i_radius <= rad;
        i_bessel_order <= n; i_layer_number <= l; i_far_side <= far;
        do @(posedge i_clk); while (!o_in_ready);
        pending_coeffs.push_back(shift_coeff(amp, ph, rad, n, l, far));
    endtask

    task automatic send_random();
        send_coeff(24'($urandom), 16'($urandom),
                   ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1023)),
                   8'($urandom), 12'($urandom), 1'($urandom));
    endtask

    task automatic random_config(input bit extreme);
        write_reg(llps_pkg::REG_SHIFT_X,
                  extreme ? ($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000) : 24'($urandom));
        write_reg(llps_pkg::REG_TWIST_OMEGA, extreme ? 24'hFFFF : 24'($urandom));
        write_reg(llps_pkg::REG_ROTATE_PHI, extreme ? 24'hFFFF : 24'($urandom));
        write_reg(llps_pkg::REG_SHIFT_Z,
                  extreme ? ($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000) : 24'($urandom));
        write_reg(llps_pkg::REG_INV_PITCH, extreme ? 24'hFFFFFF : 24'($urandom));
        write_reg(llps_pkg::REG_POLE_ANTI, 24'($urandom));
    endtask

    task automatic test_directed();
        send_coeff(24'h0, 16'h0, 24'h0, 8'sd0, 12'sd0, 1'b0);
        send_coeff(24'hFFFFFF, 16'h0, 24'h0, 8'sd0, 12'sd0, 1'b0);
        send_coeff(24'hFFFFFF, 16'h4000, 24'h0, 8'sd0, 12'sd0, 1'b0);
        send_coeff(24'hFFFFFF, 16'h8000, 24'h0, 8'sd0, 12'sd0, 1'b1);
        send_coeff(24'hFFFFFF, 16'hC000, 24'h0, 8'sd0, 12'sd0, 1'b1);
        send_coeff(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 8'sd127, 12'sd2047, 1'b0);
        send_coeff(24'hFFFFFF, 16'h2000, 24'hFFFFFF, -8'sd128, -12'sd2048, 1'b1);
        send_coeff(24'h123456, 16'h6000, 24'h000001, -8'sd1, 12'sd1, 1'b0);
        send_coeff(24'h123456, 16'hA000, 24'h000001, 8'sd1, -12'sd1, 1'b1);
        drain();
        random_config(1'b1);
        send_coeff(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 8'sd127, 12'sd2047, 1'b0);
        send_coeff(24'hFFFFFF, 16'h0, 24'hFFFFFF, -8'sd128, -12'sd2048, 1'b1);
        send_coeff(24'hFFFFFF, 16'h7FFF, 24'h800000, -8'sd128, 12'sd2047, 1'b0);
        send_coeff(24'h000001, 16'h8001, 24'h7FFFFF, 8'sd127, -12'sd2048, 1'b1);
        drain();
        write_reg(3'd6, 24'hFFFFFF);
        write_reg(3'd7, 24'h000000);
        send_coeff(24'h800000, 16'h3FFF, 24'h0, 8'sd5, 12'sd3, 1'b0);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            random_config(ph == 2);
            for (int k = 0; k < 320; k++) send_random();
        end
    endtask

    task automatic test_stream_pause();
        for (int k = 0; k < 40; k++) send_random();
        drain();
        for (int k = 0; k < 40; k++) send_random();
    endtask

    always begin
        int stall;
        stall = $urandom_range(0, 8);
        @(negedge i_clk);
        i_out_ready <= (stall == 0);
        if (stall != 0) begin
            repeat (stall) @(negedge i_clk);
            i_out_ready <= 1'b1;
        end
        @(posedge i_clk);
        while (!o_out_valid) @(posedge i_clk);
    end

    always @(posedge i_clk) begin
        t_coeff_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_coeffs.size() == 0) begin
                $error("unexpected result phase_out=%0h", o_phase_out);
                failed = 1'b1;
            end else begin
                want = pending_coeffs.pop_front();
                if (o_phase_out !== want.phase) begin
                    $error("phase_out exp %0h got %0h", want.phase, o_phase_out);
                    failed = 1'b1;
                end
                if (o_real_part !== want.re) begin
                    $error("real_part exp %0d got %0d", want.re, o_real_part);
                    failed = 1'b1;
                end
                if (o_imag_part !== want.im) begin
                    $error("imag_part exp %0d got %0d", want.im, o_imag_part);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_stream_pause();
        test_random_phases();
        drain();
        if (!failed && pending_coeffs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> files.f
rtl/core/llps_pkg.sv
rtl/core/llps_cordic.sv
rtl/core/layer_line_phase_shift.sv
tb/layer_line_phase_shift_tb.sv
